// ===== hw/rtl/prs_pkg.sv =====
// Shared types and constants for the period running statistics block.
package prs_pkg;

  // Request kinds carried on the input tuser
  localparam logic [1:0] REQ_SAMPLE  = 2'd0;
  localparam logic [1:0] REQ_TIMEOUT = 2'd1;
  localparam logic [1:0] REQ_CLEAR   = 2'd2;

  localparam int unsigned REQ_W      = 2;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned MEAN_OUT_W = 48;
  localparam int unsigned M2_W       = 64;
  localparam int unsigned DIGIT_W    = 16;
  localparam int unsigned IN_DATA_W  = 2 * VAL_W;
  localparam int unsigned OUT_DATA_W = 6 * VAL_W + MEAN_OUT_W + M2_W;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MEAN,
    ST_MAG,
    ST_MUL,
    ST_ACC,
    ST_PUB
  } state_e;

  // Commands from controller to datapath and output register
  typedef struct packed {
    logic load;
    logic div_step;
    logic mean_upd;
    logic mul_load;
    logic mul_step;
    logic m2_upd;
    logic publish;
  } cmd_t;

  // Current statistics as seen by the output stage
  typedef struct packed {
    logic                  sample_seen;
    logic [VAL_W-1:0]      sample_count;
    logic [VAL_W-1:0]      timeout_total;
    logic [VAL_W-1:0]      min_period;
    logic [VAL_W-1:0]      max_period;
    logic [VAL_W-1:0]      min_clock;
    logic [VAL_W-1:0]      max_clock;
    logic [MEAN_OUT_W-1:0] mean_period;
    logic [M2_W-1:0]       sum_sq_dev;
  } stats_t;

endpackage

// ===== hw/rtl/prs_ctrl.sv =====
// Sequencer for one request: load, serial divide, mean update, magnitude load, digit multiply, M2 add, publish.
module prs_ctrl #(
  parameter int unsigned DIV_STEPS = 48,
  parameter int unsigned MUL_STEPS = 3
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [prs_pkg::REQ_W-1:0] req_type_i,
  input  logic                      out_free_i,
  output logic                      in_ready_o,
  output prs_pkg::cmd_t             cmd_o
);
  import prs_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_STEPS);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             accept;
  logic             cnt_last_div;
  logic             cnt_last_mul;

  assign accept       = in_valid_i && in_ready_o;
  assign cnt_last_div = (cnt_q == CNT_W'(DIV_STEPS - 1));
  assign cnt_last_mul = (cnt_q == CNT_W'(MUL_STEPS - 1));

  // Next state and step counter
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (accept) begin
          state_d = (req_type_i == REQ_SAMPLE) ? ST_DIV : ST_PUB;
        end
      end
      ST_DIV: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_last_div) begin
          state_d = ST_MEAN;
        end
      end
      ST_MEAN: state_d = ST_MAG;
      ST_MAG: begin
        cnt_d   = '0;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_last_mul) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: state_d = ST_PUB;
      ST_PUB: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands per state
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_DIV:  cmd_o.div_step = 1'b1;
      ST_MEAN: cmd_o.mean_upd = 1'b1;
      ST_MAG:  cmd_o.mul_load = 1'b1;
      ST_MUL:  cmd_o.mul_step = 1'b1;
      ST_ACC:  cmd_o.m2_upd   = 1'b1;
      ST_PUB:  cmd_o.publish  = out_free_i;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // A sample beat always starts the divider
  a_sample_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_type_i == REQ_SAMPLE) |=> (state_q == ST_DIV))
    else $error("sample beat did not start the divider");

endmodule

// ===== hw/rtl/prs_dp.sv =====
// Statistics registers, restoring divider, digit-serial multiplier and M2 accumulator.
module prs_dp #(
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  prs_pkg::cmd_t             cmd_i,
  input  logic [prs_pkg::REQ_W-1:0] req_type_i,
  input  logic [prs_pkg::VAL_W-1:0] period_ns_i,
  input  logic [prs_pkg::VAL_W-1:0] sysclk_hz_i,
  output prs_pkg::stats_t           stats_o
);
  import prs_pkg::*;

  localparam int unsigned MW  = VALUE_WIDTH + FRAC_BITS;    // mean width
  localparam int unsigned ND  = (MW + DIGIT_W - 1) / DIGIT_W;
  localparam int unsigned MB  = ND * DIGIT_W;                // multiplier reg width
  localparam int unsigned PW  = MW + MB;                     // product width
  localparam int unsigned SH  = 2 * FRAC_BITS;

  // Statistics state
  logic             seen_q;
  logic [VAL_W-1:0] count_q, timeout_q;
  logic [VAL_W-1:0] minp_q, maxp_q, minc_q, maxc_q;
  logic [MW-1:0]    mean_q;
  logic [M2_W-1:0]  m2_q;

  // Working registers for one sample
  logic [MW-1:0]    x_q, mag1_q, quo_q;
  logic             neg_q;
  logic [VAL_W-1:0] rem_q;
  logic [MB-1:0]    mul_b_q;
  logic [PW-1:0]    acc_q;

  // Load-cycle values
  logic [VAL_W-1:0] period;
  logic [MW-1:0]    x_w, mag1_w, mag2_w;
  logic             neg_w;
  logic [VAL_W-1:0] count_inc;

  assign period    = VAL_W'(VALUE_WIDTH'(period_ns_i));
  assign x_w       = MW'(period_ns_i) << FRAC_BITS;
  assign neg_w     = x_w < mean_q;
  assign mag1_w    = neg_w ? (mean_q - x_w) : (x_w - mean_q);
  assign count_inc = (count_q != '1) ? (count_q + VAL_W'(1)) : count_q;
  assign mag2_w    = neg_q ? (mean_q - x_q) : (x_q - mean_q);

  // Divider step: shift one dividend bit into the remainder
  logic [VAL_W:0] rem_sh;
  logic           rem_ge;
  assign rem_sh = {rem_q, quo_q[MW-1]};
  assign rem_ge = rem_sh >= {1'b0, count_q};

  // Multiplier step: top digit of |d2| times |d1|
  logic [MW+DIGIT_W-1:0] pp;
  logic [PW-1:0]         acc_d;
  assign pp    = mag1_q * mul_b_q[MB-1 -: DIGIT_W];
  assign acc_d = (acc_q << DIGIT_W) + PW'(pp);

  // M2 accumulate with saturation
  logic [PW+M2_W-1:0] prod_sh;
  logic               prod_ovf;
  logic [M2_W:0]      m2_sum;
  assign prod_sh  = {{M2_W{1'b0}}, acc_q} >> SH;
  assign prod_ovf = |prod_sh[PW+M2_W-1:M2_W];
  assign m2_sum   = {1'b0, m2_q} + {1'b0, prod_sh[M2_W-1:0]};

  // Statistics registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q    <= 1'b0;
      count_q   <= '0;
      timeout_q <= '0;
      minp_q    <= '0;
      maxp_q    <= '0;
      minc_q    <= '0;
      maxc_q    <= '0;
      mean_q    <= '0;
      m2_q      <= '0;
    end else begin
      if (cmd_i.load) begin
        unique case (req_type_i)
          REQ_SAMPLE: begin
            seen_q  <= 1'b1;
            count_q <= count_inc;
            if (!seen_q || period < minp_q) minp_q <= period;
            if (!seen_q || period > maxp_q) maxp_q <= period;
            if (!seen_q || sysclk_hz_i < minc_q) minc_q <= sysclk_hz_i;
            if (!seen_q || sysclk_hz_i > maxc_q) maxc_q <= sysclk_hz_i;
          end
          REQ_TIMEOUT: begin
            if (timeout_q != '1) timeout_q <= timeout_q + VAL_W'(1);
          end
          REQ_CLEAR: begin
            seen_q    <= 1'b0;
            count_q   <= '0;
            timeout_q <= '0;
            minp_q    <= '0;
            maxp_q    <= '0;
            minc_q    <= '0;
            maxc_q    <= '0;
            mean_q    <= '0;
            m2_q      <= '0;
          end
          default: ;
        endcase
      end
      if (cmd_i.mean_upd) begin
        mean_q <= neg_q ? (mean_q - quo_q) : (mean_q + quo_q);
      end
      if (cmd_i.m2_upd) begin
        m2_q <= (prod_ovf || m2_sum[M2_W]) ? '1 : m2_sum[M2_W-1:0];
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q    <= x_w;
      neg_q  <= neg_w;
      mag1_q <= mag1_w;
      quo_q  <= mag1_w;
      rem_q  <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_ge ? VAL_W'(rem_sh - {1'b0, count_q}) : rem_sh[VAL_W-1:0];
      quo_q <= {quo_q[MW-2:0], rem_ge};
    end
    if (cmd_i.mul_load) begin
      mul_b_q <= MB'(mag2_w);
      acc_q   <= '0;
    end
    if (cmd_i.mul_step) begin
      acc_q   <= acc_d;
      mul_b_q <= mul_b_q << DIGIT_W;
    end
  end

  always_comb begin
    stats_o.sample_seen   = seen_q;
    stats_o.sample_count  = count_q;
    stats_o.timeout_total = timeout_q;
    stats_o.min_period    = minp_q;
    stats_o.max_period    = maxp_q;
    stats_o.min_clock     = minc_q;
    stats_o.max_clock     = maxc_q;
    stats_o.mean_period   = MEAN_OUT_W'(mean_q);
    stats_o.sum_sq_dev    = m2_q;
  end

  // Count saturates, so it is nonzero exactly when a sample was seen
  a_seen_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q == (count_q != '0))
    else $error("seen flag and sample count disagree");

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q |-> (minp_q <= maxp_q && minc_q <= maxc_q))
    else $error("min exceeds max");

endmodule

// ===== hw/rtl/period_running_statistics_top.sv =====
// Sample request: load, serial divide, mean update, magnitude load, digit multiply, M2 add
// and publish; publish waits until the output register is free. No input beat is taken
// until a request has published. The bit-serial divider (one quotient bit a cycle) is the
// longest step. Timeout, clear and unused codes go from the beat straight to publish.
// The output register lets the next input beat in while a result waits.
// Reset (rst_ni low, asynchronous) zeroes all statistics and empties the output.
module period_running_statistics_top #(
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // period_ns [31:0], sysclk_hz [63:32]
  input  logic [prs_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // req_type [1:0]
  input  logic [prs_pkg::REQ_W-1:0]      s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // sample_count [31:0], timeout_total [63:32], min_period [95:64],
  // max_period [127:96], min_clock [159:128], max_clock [191:160],
  // mean_period [239:192], sum_sq_dev [303:240]
  output logic [prs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // sample_seen [0]
  output logic                           m_axis_tuser
);
  import prs_pkg::*;

  localparam int unsigned MW = VALUE_WIDTH + FRAC_BITS;

  cmd_t   cmd;
  stats_t stats;
  stats_t out_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free = !out_valid_q || m_axis_tready;

  prs_ctrl #(
    .DIV_STEPS (MW),
    .MUL_STEPS ((MW + DIGIT_W - 1) / DIGIT_W)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .req_type_i (s_axis_tuser),
    .out_free_i (out_free),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  prs_dp #(
    .FRAC_BITS   (FRAC_BITS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .req_type_i   (s_axis_tuser),
    .period_ns_i  (s_axis_tdata[VAL_W-1:0]),
    .sysclk_hz_i  (s_axis_tdata[IN_DATA_W-1:VAL_W]),
    .stats_o      (stats)
  );

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.publish) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (cmd.publish) begin
      out_q <= stats;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.sample_seen;
  assign m_axis_tdata  = {out_q.sum_sq_dev, out_q.mean_period, out_q.max_clock,
                          out_q.min_clock, out_q.max_period, out_q.min_period,
                          out_q.timeout_total, out_q.sample_count};

  // A new result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.publish |-> !(out_valid_q && !m_axis_tready))
    else $error("result overwritten before it was taken");

endmodule
